// File: hw/rtl/cau_pkg.sv
// Package of the complex arithmetic unit: data widths, opcodes and the
// request and response word types. No dependencies.
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int SUM_W      = PROD_W + 1;
   localparam int NUM_W      = PROD_W + FRAC_BITS;
   localparam int REM_W      = PROD_W;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      op_type                        op;
      logic signed [DATA_WIDTH-1:0] a_re;
      logic signed [DATA_WIDTH-1:0] a_im;
      logic signed [DATA_WIDTH-1:0] b_re;
      logic signed [DATA_WIDTH-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] res_re;
      logic signed [DATA_WIDTH-1:0] res_im;
      logic                         div_zero;
      logic                         sat_flag;
   } rsp_type;

endpackage

// File: hw/rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: pipelined add, subtract, multiply and divide.
// Depends on cau_pkg for widths, opcodes and the request and response words.

// The unit takes one word per cycle while results are taken at the output.
// Most of its stages are the divider, a restoring divider that resolves one
// quotient bit per stage for both result parts; every operation runs through
// the same stages so that results come out in order. The whole pipeline holds
// while a result waits at the output and is not taken.
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef struct packed {
      logic                    valid;
      logic                    div;
      logic                    dz;
      logic                    neg_re;
      logic                    neg_im;
      logic [NUM_W-1:0]        num_re;
      logic [NUM_W-1:0]        num_im;
      logic [REM_W-1:0]        rem_re;
      logic [REM_W-1:0]        rem_im;
      logic [PROD_W-1:0]       den;
   } stage_type;

   localparam logic signed [NUM_W:0] SAT_MAX =
      (NUM_W+1)'((longint'(1) <<< (DATA_WIDTH-1)) - longint'(1));
   localparam logic signed [NUM_W:0] SAT_MIN =
      (NUM_W+1)'(-(longint'(1) <<< (DATA_WIDTH-1)));

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Stage 1: operand register.
   logic    s1_valid_ff;
   req_type s1_ff;

   // Stage 2: products, plain sums and differences.
   logic                     s2_valid_ff;
   op_type                   s2_op_ff;
   logic signed [PROD_W-1:0] s2_rr_ff, s2_ii_ff, s2_ri_ff, s2_ir_ff;
   logic        [PROD_W-1:0] s2_bb_re_ff, s2_bb_im_ff;
   logic signed [DATA_WIDTH:0] s2_add_re_ff, s2_add_im_ff, s2_sub_re_ff, s2_sub_im_ff;

   // Stage 3: combined parts and divisor.
   logic                    s3_valid_ff;
   op_type                  s3_op_ff;
   logic signed [SUM_W-1:0] s3_re_ff, s3_im_ff;
   logic       [PROD_W-1:0] s3_den_ff;

   // Divider stages; index zero is the entry register.
   stage_type dv_ff [NUM_W+1];
   stage_type dv_in [NUM_W+1];
   stage_type dv_head;

   // Final value stage.
   logic                    fin_valid_ff;
   logic                    fin_dz_ff;
   logic signed [NUM_W:0]   fin_re_ff, fin_im_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Divider entry from stage 3.
   always_comb begin
      logic signed [SUM_W-1:0] sh_re, sh_im;
      logic        [PROD_W-1:0] mag_re, mag_im;
      sh_re  = s3_re_ff >>> FRAC_BITS;
      sh_im  = s3_im_ff >>> FRAC_BITS;
      mag_re = s3_re_ff[SUM_W-1] ? PROD_W'(-s3_re_ff) : PROD_W'(s3_re_ff);
      mag_im = s3_im_ff[SUM_W-1] ? PROD_W'(-s3_im_ff) : PROD_W'(s3_im_ff);
      dv_head.valid  = s3_valid_ff;
      dv_head.div    = (s3_op_ff == OP_DIV);
      dv_head.dz     = (s3_op_ff == OP_DIV) && (s3_den_ff == '0);
      dv_head.neg_re = s3_re_ff[SUM_W-1];
      dv_head.neg_im = s3_im_ff[SUM_W-1];
      dv_head.rem_re = '0;
      dv_head.rem_im = '0;
      dv_head.den    = s3_den_ff;
      case (s3_op_ff)
         OP_DIV: begin
            dv_head.num_re = {mag_re, {FRAC_BITS{1'b0}}};
            dv_head.num_im = {mag_im, {FRAC_BITS{1'b0}}};
         end
         OP_MUL: begin
            dv_head.num_re = NUM_W'(sh_re);
            dv_head.num_im = NUM_W'(sh_im);
         end
         default: begin
            dv_head.num_re = NUM_W'(s3_re_ff);
            dv_head.num_im = NUM_W'(s3_im_ff);
         end
      endcase
   end

   // One quotient bit per stage; other operations pass through unchanged.
   always_comb begin
      dv_in[0] = dv_head;
      for (int k = 1; k <= NUM_W; k++) begin
         logic [REM_W:0] t_re, t_im;
         logic           ge_re, ge_im;
         t_re  = {dv_ff[k-1].rem_re, dv_ff[k-1].num_re[NUM_W-1]};
         t_im  = {dv_ff[k-1].rem_im, dv_ff[k-1].num_im[NUM_W-1]};
         ge_re = t_re >= {1'b0, dv_ff[k-1].den};
         ge_im = t_im >= {1'b0, dv_ff[k-1].den};
         dv_in[k] = dv_ff[k-1];
         if (dv_ff[k-1].div) begin
            dv_in[k].rem_re = ge_re ? REM_W'(t_re - {1'b0, dv_ff[k-1].den}) : REM_W'(t_re);
            dv_in[k].rem_im = ge_im ? REM_W'(t_im - {1'b0, dv_ff[k-1].den}) : REM_W'(t_im);
            dv_in[k].num_re = {dv_ff[k-1].num_re[NUM_W-2:0], ge_re};
            dv_in[k].num_im = {dv_ff[k-1].num_im[NUM_W-2:0], ge_im};
         end
      end
   end

   logic signed [NUM_W:0] fin_re_in, fin_im_in;
   always_comb begin
      logic signed [NUM_W:0] q_re, q_im;
      q_re = $signed({1'b0, dv_ff[NUM_W].num_re});
      q_im = $signed({1'b0, dv_ff[NUM_W].num_im});
      if (dv_ff[NUM_W].div) begin
         fin_re_in = dv_ff[NUM_W].neg_re ? -q_re : q_re;
         fin_im_in = dv_ff[NUM_W].neg_im ? -q_im : q_im;
      end else begin
         fin_re_in = $signed({dv_ff[NUM_W].num_re[NUM_W-1], dv_ff[NUM_W].num_re});
         fin_im_in = $signed({dv_ff[NUM_W].num_im[NUM_W-1], dv_ff[NUM_W].num_im});
      end
   end

   rsp_type rsp_data_in;
   always_comb begin
      logic hi_re, lo_re, hi_im, lo_im;
      hi_re = fin_re_ff > SAT_MAX;
      lo_re = fin_re_ff < SAT_MIN;
      hi_im = fin_im_ff > SAT_MAX;
      lo_im = fin_im_ff < SAT_MIN;
      if (fin_dz_ff) begin
         rsp_data_in = '0;
         rsp_data_in.div_zero = 1'b1;
      end else begin
         rsp_data_in.res_re = hi_re ? DATA_WIDTH'(SAT_MAX) :
                              lo_re ? DATA_WIDTH'(SAT_MIN) : DATA_WIDTH'(fin_re_ff);
         rsp_data_in.res_im = hi_im ? DATA_WIDTH'(SAT_MAX) :
                              lo_im ? DATA_WIDTH'(SAT_MIN) : DATA_WIDTH'(fin_im_ff);
         rsp_data_in.div_zero = 1'b0;
         rsp_data_in.sat_flag = hi_re || lo_re || hi_im || lo_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= NUM_W; k++) begin
            dv_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         fin_valid_ff <= dv_ff[NUM_W].valid;
         rsp_valid_ff <= fin_valid_ff;
         for (int k = 0; k <= NUM_W; k++) begin
            dv_ff[k].valid <= dv_in[k].valid;
         end
      end
      if (advance) begin
         s1_ff        <= req_data;
         s2_op_ff     <= s1_ff.op;
         s2_rr_ff     <= PROD_W'(s1_ff.a_re * s1_ff.b_re);
         s2_ii_ff     <= PROD_W'(s1_ff.a_im * s1_ff.b_im);
         s2_ri_ff     <= PROD_W'(s1_ff.a_re * s1_ff.b_im);
         s2_ir_ff     <= PROD_W'(s1_ff.a_im * s1_ff.b_re);
         s2_bb_re_ff  <= PROD_W'(s1_ff.b_re * s1_ff.b_re);
         s2_bb_im_ff  <= PROD_W'(s1_ff.b_im * s1_ff.b_im);
         s2_add_re_ff <= (DATA_WIDTH+1)'(s1_ff.a_re) + (DATA_WIDTH+1)'(s1_ff.b_re);
         s2_add_im_ff <= (DATA_WIDTH+1)'(s1_ff.a_im) + (DATA_WIDTH+1)'(s1_ff.b_im);
         s2_sub_re_ff <= (DATA_WIDTH+1)'(s1_ff.a_re) - (DATA_WIDTH+1)'(s1_ff.b_re);
         s2_sub_im_ff <= (DATA_WIDTH+1)'(s1_ff.a_im) - (DATA_WIDTH+1)'(s1_ff.b_im);
         s3_op_ff     <= s2_op_ff;
         s3_den_ff    <= s2_bb_re_ff + s2_bb_im_ff;
         case (s2_op_ff)
            OP_ADD: begin
               s3_re_ff <= SUM_W'(s2_add_re_ff);
               s3_im_ff <= SUM_W'(s2_add_im_ff);
            end
            OP_SUB: begin
               s3_re_ff <= SUM_W'(s2_sub_re_ff);
               s3_im_ff <= SUM_W'(s2_sub_im_ff);
            end
            OP_MUL: begin
               s3_re_ff <= SUM_W'(s2_rr_ff) - SUM_W'(s2_ii_ff);
               s3_im_ff <= SUM_W'(s2_ri_ff) + SUM_W'(s2_ir_ff);
            end
            default: begin
               s3_re_ff <= SUM_W'(s2_rr_ff) + SUM_W'(s2_ii_ff);
               s3_im_ff <= SUM_W'(s2_ir_ff) - SUM_W'(s2_ri_ff);
            end
         endcase
         for (int k = 0; k <= NUM_W; k++) begin
            dv_ff[k].div    <= dv_in[k].div;
            dv_ff[k].dz     <= dv_in[k].dz;
            dv_ff[k].neg_re <= dv_in[k].neg_re;
            dv_ff[k].neg_im <= dv_in[k].neg_im;
            dv_ff[k].num_re <= dv_in[k].num_re;
            dv_ff[k].num_im <= dv_in[k].num_im;
            dv_ff[k].rem_re <= dv_in[k].rem_re;
            dv_ff[k].rem_im <= dv_in[k].rem_im;
            dv_ff[k].den    <= dv_in[k].den;
         end
         fin_dz_ff   <= dv_ff[NUM_W].dz;
         fin_re_ff   <= fin_re_in;
         fin_im_ff   <= fin_im_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: test/tb_complex_arithmetic_unit.sv
// Testbench of the complex arithmetic unit: directed corner cases and random
// words under varied back-pressure, checked against an in-bench predictor.
// Depends on cau_pkg and complex_arithmetic_unit.
module tb_complex_arithmetic_unit;
   import cau_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint MAX_PART = 32767;
   localparam longint MIN_PART = -32768;

   class cau_scoreboard;
      rsp_type expected_words[$];
      int      errors;
      int      checked;

      function new();
         errors  = 0;
         checked = 0;
      endfunction

      function logic signed [DATA_WIDTH-1:0] clamp(longint v, ref logic flag);
         if (v > MAX_PART) begin
            flag = 1'b1;
            return MAX_PART[DATA_WIDTH-1:0];
         end
         if (v < MIN_PART) begin
            flag = 1'b1;
            return MIN_PART[DATA_WIDTH-1:0];
         end
         return v[DATA_WIDTH-1:0];
      endfunction

      function void note_request(req_type r);
         longint  ar, ai, br, bi, re, im, den;
         logic    sf;
         rsp_type w;
         ar = r.a_re;
         ai = r.a_im;
         br = r.b_re;
         bi = r.b_im;
         sf = 1'b0;
         w.div_zero = 1'b0;
         case (r.op)
            OP_ADD: begin
               re = ar + br;
               im = ai + bi;
            end
            OP_SUB: begin
               re = ar - br;
               im = ai - bi;
            end
            OP_MUL: begin
               re = (ar * br - ai * bi) >>> FRAC_BITS;
               im = (ar * bi + ai * br) >>> FRAC_BITS;
            end
            default: begin
               den = br * br + bi * bi;
               if (den == 0) begin
                  w.div_zero = 1'b1;
                  re = 0;
                  im = 0;
               end else begin
                  // SystemVerilog signed division truncates toward zero.
                  re = ((ar * br + ai * bi) <<< FRAC_BITS) / den;
                  im = ((ai * br - ar * bi) <<< FRAC_BITS) / den;
               end
            end
         endcase
         w.res_re = clamp(re, sf);
         w.res_im = clamp(im, sf);
         w.sat_flag = sf;
         expected_words.push_back(w);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_w;
         if (expected_words.size() == 0) begin
            errors++;
            $display("%0t: response word with none expected: %h", $realtime, got);
            return;
         end
         exp_w = expected_words.pop_front();
         checked++;
         if (got.res_re !== exp_w.res_re) begin
            errors++;
            $display("%0t: res_re expected %0d actual %0d", $realtime,
                     exp_w.res_re, got.res_re);
         end
         if (got.res_im !== exp_w.res_im) begin
            errors++;
            $display("%0t: res_im expected %0d actual %0d", $realtime,
                     exp_w.res_im, got.res_im);
         end
         if (got.div_zero !== exp_w.div_zero) begin
            errors++;
            $display("%0t: div_zero expected %b actual %b", $realtime,
                     exp_w.div_zero, got.div_zero);
         end
         if (got.sat_flag !== exp_w.sat_flag) begin
            errors++;
            $display("%0t: sat_flag expected %b actual %b", $realtime,
                     exp_w.sat_flag, got.sat_flag);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   cau_scoreboard sb;
   int tx_idle_pct;
   int rx_idle_pct;
   int sent_count;

   complex_arithmetic_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sink side: random back-pressure and checking of every taken word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   task automatic send_word(req_type r);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      sent_count++;
   endtask

   task automatic send_parts(op_type op, int ar, int ai, int br, int bi);
      req_type r;
      r.op   = op;
      r.a_re = ar[DATA_WIDTH-1:0];
      r.a_im = ai[DATA_WIDTH-1:0];
      r.b_re = br[DATA_WIDTH-1:0];
      r.b_im = bi[DATA_WIDTH-1:0];
      send_word(r);
   endtask

   // Full-range values half the time, with a share of extremes and small magnitudes.
   function automatic logic [DATA_WIDTH-1:0] pick_part();
      case ($urandom_range(9))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(512)) - 256);
         4: return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(int count);
      req_type r;
      repeat (count) begin
         r.op   = op_type'($urandom_range(3));
         r.a_re = pick_part();
         r.a_im = pick_part();
         r.b_re = pick_part();
         r.b_im = pick_part();
         if ($urandom_range(19) == 0) begin
            r.b_re = '0;
            r.b_im = '0;
         end
         send_word(r);
      end
   endtask

   initial begin
      #2ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int wait_cycles;
      sb = new();
      sent_count = 0;
      tx_idle_pct = 24;
      rx_idle_pct = 46;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_parts(OP_ADD, 0, 0, 0, 0);
      send_parts(OP_ADD, 32767, 32767, 1, 32767);
      send_parts(OP_ADD, -32768, -32768, -1, -32768);
      send_parts(OP_ADD, 32767, -32768, -32768, 32767);
      send_parts(OP_SUB, -32768, 32767, 32767, -32768);
      send_parts(OP_SUB, 32767, -32768, -1, 1);
      send_parts(OP_SUB, 256, -256, 256, -256);
      send_parts(OP_MUL, -32768, -32768, -32768, -32768);
      send_parts(OP_MUL, 32767, 32767, 32767, -32768);
      send_parts(OP_MUL, 256, 0, -1, 0);
      send_parts(OP_MUL, -1, -1, 1, 1);
      send_parts(OP_MUL, 384, -128, 512, 256);
      send_parts(OP_DIV, 1000, -2000, 0, 0);
      send_parts(OP_DIV, 0, 0, 0, 0);
      send_parts(OP_DIV, 32767, -32768, 1, 0);
      send_parts(OP_DIV, -32768, -32768, 0, -1);
      send_parts(OP_DIV, 512, 256, 256, 0);
      send_parts(OP_DIV, -1, 1, 32767, 32767);
      send_parts(OP_DIV, 768, -300, -512, 128);
      send_parts(OP_DIV, -32768, -32768, -32768, -32768);
      send_parts(OP_DIV, 3, -5, 7, 2);

      send_random(510);
      tx_idle_pct = 46;
      rx_idle_pct = 24;
      send_random(510);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random(510);
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (sb.expected_words.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (100) @(posedge clock);
      if (sb.expected_words.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d expected words never arrived", $realtime,
                  sb.expected_words.size());
      end

      $display("Sent %0d words across add, subtract, multiply and divide;",
               sent_count);
      $display("checked %0d responses under three back-pressure profiles.", sb.checked);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
